>>> design/dhck_pkg.sv
// dhck_pkg: shared types and codes for the hit calibration and kinematics core
// no dependencies

package dhck_pkg;

    typedef enum logic [1:0] {
        OP_GAIN_LOAD  = 2'd0,
        OP_ANGLE_LOAD = 2'd1,
        OP_RING_HIT   = 2'd2,
        OP_SECTOR_HIT = 2'd3
    } t_op;

    localparam logic [7:0] CFG_BEAM_ENERGY = 8'd0;
    localparam logic [7:0] CFG_GROUND_Q    = 8'd1;
    localparam logic [7:0] CFG_COEF_EJECT  = 8'd2;
    localparam logic [7:0] CFG_COEF_BEAM   = 8'd3;
    localparam logic [7:0] CFG_COEF_CROSS  = 8'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int SQRT_STEPS  = 28;

    typedef struct packed {
        logic [19:0]        beam;
        logic signed [17:0] q;
        logic signed [18:0] ce;
        logic signed [18:0] cb;
        logic signed [18:0] cc;
    } t_cfg;

    // one hit with its table data, as it crosses the queue
    typedef struct packed {
        logic [2:0]         det;
        logic [5:0]         ch;
        logic               sec;
        logic [15:0]        raw;
        logic signed [23:0] off;
        logic [23:0]        gain;
        logic [15:0]        deg;
        logic signed [17:0] cos;
    } t_hit;

    // sideband carried alongside the root pipeline
    typedef struct packed {
        logic [2:0]         det;
        logic [5:0]         ch;
        logic               sec;
        logic [15:0]        raw;
        logic signed [31:0] cal;
        logic               flag;
        logic [15:0]        deg;
        logic signed [20:0] k;
        logic signed [55:0] s0;
    } t_side;

endpackage

>>> design/detector_hit_calibration_kinematics_core.sv
// detector_hit_calibration_kinematics_core: top level, configuration registers
// depends on dhck_pkg, dhck_front, dhck_queue, dhck_back
//
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_stall    opcode, detector, channel, raw, load fields
// out       output     o_out_valid / i_out_stall  detector, channel, sector, energies, angle
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// one item per cycle while the output does not stall; a hit passes, in order, through the
// table lookup at the taking edge, a queue slot, four arithmetic stages, a 28 stage root
// pipeline, the cross product and the output register.
// loads write the tables and give no transfer on the output channel.
// sync reset clears control state, loads config defaults; tables hold junk until loaded.
// an output stall freezes the back pipeline; the four entry queue then fills
// and raises o_in_stall.

module detector_hit_calibration_kinematics_core
    import dhck_pkg::*;
#(
    parameter int DETECTORS = 8,
    parameter int STRIPS    = 32,
    parameter int RAW_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [2:0]         i_detector,
    input  logic [5:0]         i_channel,
    input  logic [15:0]        i_raw_energy,
    input  logic signed [23:0] i_load_offset,
    input  logic [23:0]        i_load_gain,
    input  logic [15:0]        i_load_angle_deg,
    input  logic signed [17:0] i_load_angle_cos,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_out_detector,
    output logic [5:0]         o_out_channel,
    output logic               o_is_sector,
    output logic [15:0]        o_raw_echo,
    output logic signed [31:0] o_calibrated_energy,
    output logic signed [31:0] o_excitation_energy,
    output logic [15:0]        o_angle_deg,
    output logic               o_clamped
);

    t_cfg r_cfg;
    logic push, pop, q_empty;
    t_hit push_hit, q_hit;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.beam <= 20'd227000;
            r_cfg.q    <= 18'sd10087;
            r_cfg.ce   <= 19'sd67669;
            r_cfg.cb   <= 19'sd2106;
            r_cfg.cc   <= 19'sd23260;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BEAM_ENERGY: r_cfg.beam <= i_cfg_data;
                CFG_GROUND_Q:    r_cfg.q    <= i_cfg_data[17:0];
                CFG_COEF_EJECT:  r_cfg.ce   <= i_cfg_data[18:0];
                CFG_COEF_BEAM:   r_cfg.cb   <= i_cfg_data[18:0];
                CFG_COEF_CROSS:  r_cfg.cc   <= i_cfg_data[18:0];
                default: ;
            endcase
        end
    end

    dhck_front #(.DETECTORS(DETECTORS), .STRIPS(STRIPS)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_detector       (i_detector),
        .i_channel        (i_channel),
        .i_raw_energy     (i_raw_energy),
        .i_load_offset    (i_load_offset),
        .i_load_gain      (i_load_gain),
        .i_load_angle_deg (i_load_angle_deg),
        .i_load_angle_cos (i_load_angle_cos),
        .i_q_count        (q_count),
        .o_push           (push),
        .o_hit            (push_hit)
    );

    dhck_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_hit   (push_hit),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_hit   (q_hit),
        .o_count (q_count)
    );

    dhck_back #(.RAW_BITS(RAW_BITS)) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_q_empty           (q_empty),
        .i_q_hit             (q_hit),
        .o_q_pop             (pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_detector      (o_out_detector),
        .o_out_channel       (o_out_channel),
        .o_is_sector         (o_is_sector),
        .o_raw_echo          (o_raw_echo),
        .o_calibrated_energy (o_calibrated_energy),
        .o_excitation_energy (o_excitation_energy),
        .o_angle_deg         (o_angle_deg),
        .o_clamped           (o_clamped)
    );

endmodule

>>> design/dhck_ram.sv
// dhck_ram: generic single write port, single read port ram with registered read
// no dependencies

module dhck_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/dhck_front.sv
// dhck_front: accepts items, writes the gain and angle tables, looks up hits
// depends on dhck_pkg and dhck_ram

module dhck_front
    import dhck_pkg::*;
#(
    parameter int DETECTORS = 8,
    parameter int STRIPS    = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_opcode,
    input  logic [2:0]                        i_detector,
    input  logic [5:0]                        i_channel,
    input  logic [15:0]                       i_raw_energy,
    input  logic signed [23:0]                i_load_offset,
    input  logic [23:0]                       i_load_gain,
    input  logic [15:0]                       i_load_angle_deg,
    input  logic signed [17:0]                i_load_angle_cos,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]  i_q_count,
    output logic                              o_push,
    output t_hit                              o_hit
);

    localparam int GDEPTH = DETECTORS * 2 * STRIPS;
    localparam int GW     = $clog2(GDEPTH > 1 ? GDEPTH : 2);
    localparam int AW     = $clog2(STRIPS > 1 ? STRIPS : 2);

    logic          accept, ch_ok, det_ok, sec_slot;
    logic          gain_we, angle_we, is_hit;
    t_op           op;
    logic [GW-1:0] gidx;
    logic [AW-1:0] aidx;
    logic [47:0]   gain_q;
    logic [33:0]   angle_q;

    logic          r_f1_v;
    logic [2:0]    r_f1_det;
    logic [5:0]    r_f1_ch;
    logic          r_f1_sec;
    logic [15:0]   r_f1_raw;

    // room for the item in the lookup stage plus the new one
    assign o_in_stall = (32'(i_q_count) + 32'(r_f1_v)) > (QUEUE_DEPTH - 1);
    assign accept     = i_in_valid && !o_in_stall;

    assign op     = t_op'(i_opcode);
    assign ch_ok  = (i_channel != 6'd0) && (32'(i_channel) <= STRIPS);
    assign det_ok = 32'(i_detector) < DETECTORS;
    assign is_hit = (op == OP_RING_HIT) || (op == OP_SECTOR_HIT);

    // gain loads pick the slot from raw bit 0, hits from the opcode
    assign sec_slot = (op == OP_GAIN_LOAD) ? i_raw_energy[0] : (op == OP_SECTOR_HIT);
    assign gidx = GW'(32'(i_detector) * (2 * STRIPS) + (sec_slot ? STRIPS : 0)
                      + 32'(i_channel) - 1);
    assign aidx = AW'(32'(i_channel) - 1);

    assign gain_we  = accept && (op == OP_GAIN_LOAD) && ch_ok && det_ok;
    assign angle_we = accept && (op == OP_ANGLE_LOAD) && ch_ok;

    dhck_ram #(.WIDTH(48), .DEPTH(GDEPTH)) u_gain_ram (
        .i_clk   (i_clk),
        .i_we    (gain_we),
        .i_waddr (gidx),
        .i_wdata ({i_load_offset, i_load_gain}),
        .i_raddr (gidx),
        .o_rdata (gain_q)
    );

    dhck_ram #(.WIDTH(34), .DEPTH(STRIPS)) u_angle_ram (
        .i_clk   (i_clk),
        .i_we    (angle_we),
        .i_waddr (aidx),
        .i_wdata ({i_load_angle_deg, i_load_angle_cos}),
        .i_raddr (aidx),
        .o_rdata (angle_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else begin
            r_f1_v <= accept && is_hit && ch_ok && det_ok;
        end
        r_f1_det <= i_detector;
        r_f1_ch  <= i_channel;
        r_f1_sec <= (op == OP_SECTOR_HIT);
        r_f1_raw <= i_raw_energy;
    end

    assign o_push = r_f1_v;
    always_comb begin
        o_hit      = '0;
        o_hit.det  = r_f1_det;
        o_hit.ch   = r_f1_ch;
        o_hit.sec  = r_f1_sec;
        o_hit.raw  = r_f1_raw;
        o_hit.off  = gain_q[47:24];
        o_hit.gain = gain_q[23:0];
        o_hit.deg  = angle_q[33:18];
        o_hit.cos  = angle_q[17:0];
    end

endmodule

>>> design/dhck_queue.sv
// dhck_queue: short fifo of looked-up hits between front and back
// depends on dhck_pkg

module dhck_queue
    import dhck_pkg::*;
(
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  t_hit                             i_hit,
    input  logic                             i_pop,
    output logic                             o_empty,
    output t_hit                             o_hit,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_hit          r_buf [0:QUEUE_DEPTH-1];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;
    logic          do_pop;

    assign o_empty = (r_count == '0);
    assign do_pop  = i_pop && !o_empty;
    assign o_hit   = r_buf[r_rp];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(do_pop);
        end
        if (i_push) begin
            r_buf[r_wp] <= i_hit;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (32'(r_count) < QUEUE_DEPTH) || do_pop)
        else $error("queue push while full");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= QUEUE_DEPTH)
        else $error("queue count out of range");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !do_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count did not follow push");
`endif

endmodule

>>> design/dhck_back.sv
// dhck_back: calibration, pipelined integer root and excitation energy
// depends on dhck_pkg

module dhck_back
    import dhck_pkg::*;
#(
    parameter int RAW_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_empty,
    input  t_hit               i_q_hit,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_out_detector,
    output logic [5:0]         o_out_channel,
    output logic               o_is_sector,
    output logic [15:0]        o_raw_echo,
    output logic signed [31:0] o_calibrated_energy,
    output logic signed [31:0] o_excitation_energy,
    output logic [15:0]        o_angle_deg,
    output logic               o_clamped
);

    localparam int PW = RAW_BITS + 24;

    logic adv;

    logic               r1_v, r2_v, r3_v;
    t_hit               r1_h, r2_h;
    logic [PW-1:0]      r1_prod;
    logic signed [31:0] r2_cal;
    logic               r2_flag;
    t_side              r3_s;
    logic [50:0]        r3_n;
    logic signed [50:0] r3_pce;
    logic signed [39:0] r3_pcb;
    logic signed [36:0] r3_pcc;

    logic               r_sq_v [0:SQRT_STEPS];
    t_side              r_sq_s [0:SQRT_STEPS];
    logic [55:0]        r_sq_n [0:SQRT_STEPS];
    logic [55:0]        r_sq_r [0:SQRT_STEPS];

    logic               r_pk_v;
    t_side              r_pk_s;
    logic signed [48:0] r_pk;

    logic               r_out_v;
    t_side              r_out_s;
    logic signed [31:0] r_out_ex;
    logic               r_out_flag;

    logic [RAW_BITS-1:0] rawv;
    logic [63:0]         pr;
    logic signed [63:0]  csum;
    logic [30:0]         tb;
    logic signed [59:0]  sum, rnd;

    // whole back pipeline moves together; the output register is its last stage
    assign adv     = !r_out_v || !i_out_stall;
    assign o_q_pop = adv && !i_q_empty;

    assign rawv = RAW_BITS'(i_q_hit.raw);
    assign pr   = (64'(r1_prod) + 64'd2048) >> 12;
    assign csum = 64'(r1_h.off) + $signed(pr);
    assign tb   = r2_cal[31] ? 31'd0 : r2_cal[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (adv) begin
            r1_v <= !i_q_empty;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
        if (adv) begin
            // calibration multiply
            r1_h    <= i_q_hit;
            r1_prod <= PW'(rawv) * PW'(i_q_hit.gain);
            // offset, rounding and saturation
            r2_h <= r1_h;
            if (csum > 64'sd2147483647) begin
                r2_cal  <= 32'sh7FFFFFFF;
                r2_flag <= 1'b1;
            end else if (csum < -64'sd2147483648) begin
                r2_cal  <= 32'sh80000000;
                r2_flag <= 1'b1;
            end else begin
                r2_cal  <= 32'(csum);
                r2_flag <= 1'b0;
            end
            // kinematic products
            r3_s.det  <= r2_h.det;
            r3_s.ch   <= r2_h.ch;
            r3_s.sec  <= r2_h.sec;
            r3_s.raw  <= r2_h.raw;
            r3_s.cal  <= r2_cal;
            r3_s.flag <= r2_flag || (!r2_h.sec && r2_cal[31]);
            r3_s.deg  <= r2_h.deg;
            r3_s.k    <= '0;
            r3_s.s0   <= '0;
            r3_n      <= 51'(i_cfg.beam) * 51'(tb);
            r3_pce    <= 51'(i_cfg.ce) * 51'(r2_cal);
            r3_pcb    <= 40'(i_cfg.cb) * $signed({20'd0, i_cfg.beam});
            r3_pcc    <= 37'(i_cfg.cc) * 37'(r2_h.cos);
        end
    end

    // fold the linear terms and round the cross coefficient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (adv) begin
            r_sq_v[0] <= r3_v;
        end
        if (adv) begin
            r_sq_s[0].det  <= r3_s.det;
            r_sq_s[0].ch   <= r3_s.ch;
            r_sq_s[0].sec  <= r3_s.sec;
            r_sq_s[0].raw  <= r3_s.raw;
            r_sq_s[0].cal  <= r3_s.cal;
            r_sq_s[0].flag <= r3_s.flag;
            r_sq_s[0].deg  <= r3_s.deg;
            r_sq_s[0].k    <= 21'((r3_pcc + 37'sd32768) >>> 16);
            r_sq_s[0].s0   <= (56'(i_cfg.q) <<< 20) - 56'(r3_pce) + (56'(r3_pcb) <<< 4);
            r_sq_n[0]      <= {1'b0, r3_n, 4'd0};
            r_sq_r[0]      <= '0;
        end
    end

    // one root bit per stage, bit position 54 down to 0
    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        logic [55:0] bitv, trial;
        assign bitv  = 56'd1 << (54 - 2 * g);
        assign trial = r_sq_r[g] + bitv;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[g+1] <= 1'b0;
            end else if (adv) begin
                r_sq_v[g+1] <= r_sq_v[g];
            end
            if (adv) begin
                r_sq_s[g+1] <= r_sq_s[g];
                if (r_sq_n[g] >= trial) begin
                    r_sq_n[g+1] <= r_sq_n[g] - trial;
                    r_sq_r[g+1] <= (r_sq_r[g] >> 1) + bitv;
                end else begin
                    r_sq_n[g+1] <= r_sq_n[g];
                    r_sq_r[g+1] <= r_sq_r[g] >> 1;
                end
            end
        end
    end

    assign sum = 60'(r_pk_s.s0) + 60'(r_pk);
    assign rnd = (sum + 60'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pk_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_pk_v  <= r_sq_v[SQRT_STEPS];
            r_out_v <= r_pk_v;
        end
        if (adv) begin
            r_pk_s <= r_sq_s[SQRT_STEPS];
            r_pk   <= 49'(r_sq_s[SQRT_STEPS].k)
                      * $signed({1'b0, r_sq_r[SQRT_STEPS][27:0]});
            r_out_s <= r_pk_s;
            if (r_pk_s.sec) begin
                r_out_ex   <= '0;
                r_out_flag <= r_pk_s.flag;
            end else if (rnd > 60'sd2147483647) begin
                r_out_ex   <= 32'sh7FFFFFFF;
                r_out_flag <= 1'b1;
            end else if (rnd < -60'sd2147483648) begin
                r_out_ex   <= 32'sh80000000;
                r_out_flag <= 1'b1;
            end else begin
                r_out_ex   <= 32'(rnd);
                r_out_flag <= r_pk_s.flag;
            end
        end
    end

    assign o_out_valid         = r_out_v;
    assign o_out_detector      = r_out_s.det;
    assign o_out_channel       = r_out_s.ch;
    assign o_is_sector         = r_out_s.sec;
    assign o_raw_echo          = r_out_s.raw;
    assign o_calibrated_energy = r_out_s.cal;
    assign o_excitation_energy = r_out_ex;
    assign o_angle_deg         = r_out_s.sec ? 16'd0 : r_out_s.deg;
    assign o_clamped           = r_out_flag;

endmodule

>>> sim/dhck_checker.sv
// dhck_checker: watches the in, out and cfg ports of the calibration core,
// predicts each hit result and compares it with what the core delivers
// depends on dhck_pkg
`timescale 1ns / 1ps

module dhck_checker
    import dhck_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [2:0]         i_detector,
    input  logic [5:0]         i_channel,
    input  logic [15:0]        i_raw_energy,
    input  logic signed [23:0] i_load_offset,
    input  logic [23:0]        i_load_gain,
    input  logic [15:0]        i_load_angle_deg,
    input  logic signed [17:0] i_load_angle_cos,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [2:0]         i_out_detector,
    input  logic [5:0]         i_out_channel,
    input  logic               i_is_sector,
    input  logic [15:0]        i_raw_echo,
    input  logic signed [31:0] i_calibrated_energy,
    input  logic signed [31:0] i_excitation_energy,
    input  logic [15:0]        i_angle_deg,
    input  logic               i_clamped,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic [2:0]         det;
        logic [5:0]         ch;
        logic               sec;
        logic [15:0]        raw;
        logic signed [31:0] cal;
        logic signed [31:0] ex;
        logic [15:0]        deg;
        logic               flag;
    } t_hit_result;

    t_hit_result expected_hits[$];

    logic signed [23:0] cal_offset[512];
    logic [23:0]        cal_gain[512];
    logic [15:0]        ring_deg[32];
    logic signed [17:0] ring_cos[32];

    logic [19:0]        beam_kev;
    logic signed [17:0] q_kev;
    logic signed [18:0] ce;
    logic signed [18:0] cb;
    logic signed [18:0] cc;

    int errors = 0;
    assign o_errors  = errors;
    assign o_pending = expected_hits.size();

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_hit_result calc_hit(logic [2:0] det, logic [5:0] ch, logic sec,
                                             logic [15:0] raw);
        t_hit_result r;
        int          idx;
        longint      prod;
        longint      cal;
        longint      tb;
        longint      k;
        longint      sum;
        longint      ex;
        longint      beam16;
        longint unsigned root;
        idx    = det * 64 + (sec ? 32 : 0) + ch - 1;
        beam16 = longint'({44'd0, beam_kev}) * 16;
        r      = '0;
        r.det  = det;
        r.ch   = ch;
        r.sec  = sec;
        r.raw  = raw;
        prod   = longint'({48'd0, raw}) * longint'({40'd0, cal_gain[idx]});
        cal    = longint'(cal_offset[idx]) + ((prod + 2048) >>> 12);
        if (cal > 64'sd2147483647) begin
            cal = 64'sd2147483647;
            r.flag = 1'b1;
        end else if (cal < -64'sd2147483648) begin
            cal = -64'sd2147483648;
            r.flag = 1'b1;
        end
        r.cal = cal[31:0];
        if (!sec) begin
            tb = cal;
            // negative energy goes under the root as zero
            if (tb < 0) begin
                tb = 0;
                r.flag = 1'b1;
            end
            root = int_sqrt(longint'(beam16) * tb);
            k    = (longint'(cc) * longint'(ring_cos[ch - 1]) + 32768) >>> 16;
            sum  = longint'(q_kev) * (64'sd1 <<< 20) - longint'(ce) * cal
                 + longint'(cb) * beam16 + k * longint'(root);
            ex   = (sum + 32768) >>> 16;
            if (ex > 64'sd2147483647) begin
                ex = 64'sd2147483647;
                r.flag = 1'b1;
            end else if (ex < -64'sd2147483648) begin
                ex = -64'sd2147483648;
                r.flag = 1'b1;
            end
            r.ex  = ex[31:0];
            r.deg = ring_deg[ch - 1];
        end
        return r;
    endfunction

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        t_hit_result exp_r;
        int          idx;
        bit          ch_ok;
        if (!i_rst_n) begin
            beam_kev = 20'd227000;
            q_kev    = 18'sd10087;
            ce       = 19'sd67669;
            cb       = 19'sd2106;
            cc       = 19'sd23260;
            expected_hits.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BEAM_ENERGY: beam_kev = i_cfg_data;
                    CFG_GROUND_Q:    q_kev    = i_cfg_data[17:0];
                    CFG_COEF_EJECT:  ce       = i_cfg_data[18:0];
                    CFG_COEF_BEAM:   cb       = i_cfg_data[18:0];
                    CFG_COEF_CROSS:  cc       = i_cfg_data[18:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                ch_ok = (i_channel >= 1) && (i_channel <= 32);
                case (t_op'(i_opcode))
                    OP_GAIN_LOAD: if (ch_ok) begin
                        idx = i_detector * 64 + (i_raw_energy[0] ? 32 : 0) + i_channel - 1;
                        cal_offset[idx] = i_load_offset;
                        cal_gain[idx]   = i_load_gain;
                    end
                    OP_ANGLE_LOAD: if (ch_ok) begin
                        ring_deg[i_channel - 1] = i_load_angle_deg;
                        ring_cos[i_channel - 1] = i_load_angle_cos;
                    end
                    default: if (ch_ok) begin
                        expected_hits.push_back(calc_hit(i_detector, i_channel,
                            i_opcode == OP_SECTOR_HIT, i_raw_energy));
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_hits.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result transfer: det %0d ch %0d", $time,
                             i_out_detector, i_out_channel);
                end else begin
                    exp_r = expected_hits.pop_front();
                    check_field("detector", exp_r.det, i_out_detector);
                    check_field("channel", exp_r.ch, i_out_channel);
                    check_field("is_sector", exp_r.sec, i_is_sector);
                    check_field("raw_echo", exp_r.raw, i_raw_echo);
                    check_field("calibrated_energy", exp_r.cal, i_calibrated_energy);
                    check_field("excitation_energy", exp_r.ex, i_excitation_energy);
                    check_field("angle_deg", exp_r.deg, i_angle_deg);
                    check_field("clamped", exp_r.flag, i_clamped);
                end
            end
        end
    end

endmodule

>>> sim/tb_top.sv
// tb_top: stimulus and verdict for detector_hit_calibration_kinematics_core
// depends on dhck_pkg, the core and dhck_checker
`timescale 1ns / 1ps

module tb_top;
    import dhck_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [7:0]         i_cfg_index = '0;
    logic [19:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_opcode = OP_GAIN_LOAD;
    logic [2:0]         i_detector = '0;
    logic [5:0]         i_channel = '0;
    logic [15:0]        i_raw_energy = '0;
    logic signed [23:0] i_load_offset = '0;
    logic [23:0]        i_load_gain = '0;
    logic [15:0]        i_load_angle_deg = '0;
    logic signed [17:0] i_load_angle_cos = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b1;
    logic [2:0]         o_out_detector;
    logic [5:0]         o_out_channel;
    logic               o_is_sector;
    logic [15:0]        o_raw_echo;
    logic signed [31:0] o_calibrated_energy;
    logic signed [31:0] o_excitation_energy;
    logic [15:0]        o_angle_deg;
    logic               o_clamped;

    int  errors;
    int  pending;
    bit  no_gaps = 0;
    bit  long_hold_req = 0;
    bit  out_taken = 0;
    int  idle_cycles = 0;
    bit  gain_written[512];
    bit  angle_written[32];
    int  written_idx[$];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    detector_hit_calibration_kinematics_core dut (.*);

    dhck_checker chk (
        .i_in_stall(o_in_stall), .i_out_valid(o_out_valid),
        .i_out_detector(o_out_detector), .i_out_channel(o_out_channel),
        .i_is_sector(o_is_sector), .i_raw_echo(o_raw_echo),
        .i_calibrated_energy(o_calibrated_energy),
        .i_excitation_energy(o_excitation_energy), .i_angle_deg(o_angle_deg),
        .i_clamped(o_clamped), .o_errors(errors), .o_pending(pending), .*
    );

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) out_taken <= o_out_valid && !i_out_stall;

    // receiver: random stall per result, plus one long hold-off on request
    always @(negedge i_clk) begin
        int stall_left;
        if (!i_rst_n) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (long_hold_req) begin
                long_hold_req = 0;
                stall_left = 400;
            end else if (out_taken && stall_left == 0) begin
                stall_left = no_gaps ? 0 : $urandom_range(0, 8);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // entered and left at a falling edge
    task automatic send(logic [1:0] op, logic [2:0] det, logic [5:0] ch, logic [15:0] raw,
                        logic [23:0] off, logic [23:0] gain, logic [15:0] deg,
                        logic [17:0] cosv);
        int gap;
        i_opcode         <= op;
        i_detector       <= det;
        i_channel        <= ch;
        i_raw_energy     <= raw;
        i_load_offset    <= off;
        i_load_gain      <= gain;
        i_load_angle_deg <= deg;
        i_load_angle_cos <= cosv;
        i_in_valid       <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (ch >= 1 && ch <= 32) begin
            if (op == OP_GAIN_LOAD && !gain_written[det * 64 + (raw[0] ? 32 : 0) + ch - 1]) begin
                gain_written[det * 64 + (raw[0] ? 32 : 0) + ch - 1] = 1;
                written_idx.push_back(det * 64 + (raw[0] ? 32 : 0) + ch - 1);
            end
            if (op == OP_ANGLE_LOAD) angle_written[ch - 1] = 1;
        end
        @(negedge i_clk);
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        // loads still in the pipe cannot give a transfer
        repeat (45) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [19:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_item();
        int sel;
        int idx;
        logic [5:0] bad_ch;
        sel    = $urandom_range(0, 99);
        bad_ch = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
        if (sel < 22 || written_idx.size() == 0) begin
            send(OP_GAIN_LOAD, 3'($urandom), 6'($urandom_range(1, 32)), 16'($urandom),
                 24'($urandom),
                 ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4096)),
                 16'($urandom), 18'($urandom));
        end else if (sel < 30) begin
            send(OP_ANGLE_LOAD, 3'($urandom), 6'($urandom_range(1, 32)), 16'($urandom),
                 24'($urandom), 24'($urandom), 16'($urandom), 18'($urandom));
        end else if (sel < 35) begin
            send(t_op'($urandom_range(0, 3)), 3'($urandom), bad_ch, 16'($urandom),
                 24'($urandom), 24'($urandom), 16'($urandom), 18'($urandom));
        end else begin
            idx = written_idx[$urandom_range(0, written_idx.size() - 1)];
            if (idx % 64 >= 32)
                send(OP_SECTOR_HIT, 3'(idx / 64), 6'(idx % 32 + 1), 16'($urandom),
                     24'($urandom), 24'($urandom), 16'($urandom), 18'($urandom));
            else if (!angle_written[idx % 32])
                send(OP_ANGLE_LOAD, 3'($urandom), 6'(idx % 32 + 1), 16'($urandom),
                     24'($urandom), 24'($urandom), 16'($urandom), 18'($urandom));
            else
                send(OP_RING_HIT, 3'(idx / 64), 6'(idx % 32 + 1), 16'($urandom),
                     24'($urandom), 24'($urandom), 16'($urandom), 18'($urandom));
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // field extremes, clamping of negative energy, ignored loads and hits
        send(OP_GAIN_LOAD, 3'd0, 6'd1, 16'd0, 24'sh7FFFFF, 24'hFFFFFF, 16'd0, 18'sd0);
        send(OP_GAIN_LOAD, 3'd7, 6'd32, 16'd1, 24'sh800000, 24'd0, 16'hFFFF, 18'sd0);
        send(OP_GAIN_LOAD, 3'd7, 6'd32, 16'd0, 24'sh800000, 24'd1, 16'd0, 18'sd0);
        send(OP_GAIN_LOAD, 3'd2, 6'd0, 16'd1, 24'sd5, 24'd5, 16'd0, 18'sd0);
        send(OP_GAIN_LOAD, 3'd2, 6'd63, 16'd0, 24'sd5, 24'd5, 16'd0, 18'sd0);
        send(OP_ANGLE_LOAD, 3'd0, 6'd1, 16'd0, 24'sd0, 24'd0, 16'd46080, 18'sd65536);
        send(OP_ANGLE_LOAD, 3'd0, 6'd32, 16'd0, 24'sd0, 24'd0, 16'hFFFF, -18'sd131072);
        send(OP_ANGLE_LOAD, 3'd0, 6'd0, 16'd0, 24'sd0, 24'd0, 16'd1, 18'sd1);
        send(OP_RING_HIT, 3'd0, 6'd1, 16'hFFFF, 24'sd0, 24'd0, 16'd0, 18'sd0);
        send(OP_RING_HIT, 3'd0, 6'd1, 16'd0, 24'sd0, 24'd0, 16'd0, 18'sd0);
        send(OP_SECTOR_HIT, 3'd7, 6'd32, 16'hFFFF, 24'sd0, 24'd0, 16'd0, 18'sd0);
        send(OP_RING_HIT, 3'd7, 6'd32, 16'd0, 24'sd0, 24'd0, 16'd0, 18'sd0);
        send(OP_RING_HIT, 3'd7, 6'd32, 16'hFFFF, 24'sd0, 24'd0, 16'd0, 18'sd0);
        send(OP_RING_HIT, 3'd0, 6'd0, 16'd7, 24'sd0, 24'd0, 16'd0, 18'sd0);
        send(OP_SECTOR_HIT, 3'd0, 6'd40, 16'd7, 24'sd0, 24'd0, 16'd0, 18'sd0);

        for (int phase = 0; phase < 5; phase++) begin
            if (phase > 0) begin
                // sender holds until every result is back, then reprograms
                wait_drained();
                case (phase)
                    1: begin
                        write_reg(CFG_BEAM_ENERGY, 20'hFFFFF);
                        write_reg(CFG_GROUND_Q, 20'h1FFFF);
                        write_reg(CFG_COEF_EJECT, 20'h3FFFF);
                        write_reg(CFG_COEF_BEAM, 20'h3FFFF);
                        write_reg(CFG_COEF_CROSS, 20'h3FFFF);
                    end
                    2: begin
                        write_reg(CFG_BEAM_ENERGY, 20'd0);
                        write_reg(CFG_GROUND_Q, 20'h20000);
                        write_reg(CFG_COEF_EJECT, 20'h40000);
                        write_reg(CFG_COEF_BEAM, 20'h40000);
                        write_reg(CFG_COEF_CROSS, 20'h40000);
                    end
                    default: begin
                        write_reg(CFG_BEAM_ENERGY, 20'($urandom_range(0, 1000000)));
                        write_reg(CFG_GROUND_Q, 20'($urandom));
                        write_reg(CFG_COEF_EJECT, 20'($urandom));
                        write_reg(CFG_COEF_BEAM, 20'($urandom));
                        write_reg(CFG_COEF_CROSS, 20'($urandom));
                    end
                endcase
            end
            for (int n = 0; n < 380; n++) begin
                if (n == 100) no_gaps = 1;
                if (n == 160) no_gaps = 0;
                if (phase == 2 && n == 200) long_hold_req = 1;
                random_item();
            end
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
design/dhck_pkg.sv
design/dhck_ram.sv
design/dhck_front.sv
design/dhck_queue.sv
design/dhck_back.sv
design/detector_hit_calibration_kinematics_core.sv
sim/dhck_checker.sv
sim/tb_top.sv
